// ===== sv/awsa_pkg.sv =====
package awsa_pkg;

   localparam int WINDOW_DEPTH = 128;
   localparam int RANGE_COUNT  = 5;

   localparam int SAMPLE_W = 10;
   localparam int ADDR_W   = $clog2(WINDOW_DEPTH);
   localparam int SUM_W    = SAMPLE_W + ADDR_W;
   localparam int COUNT_W  = 16;
   localparam int RANGE_W  = 3;
   localparam int SPREAD_W = 11;
   localparam int CSR_W    = 11;

   localparam logic [COUNT_W-1:0] COUNT_CEILING = 16'd65534;
   localparam logic [COUNT_W-1:0] COUNT_GATE    = COUNT_W'(2 * WINDOW_DEPTH);
   localparam logic [RANGE_W-1:0] RANGE_TOP     = RANGE_W'(RANGE_COUNT - 1);

   localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RESET   = 10'd233;
   localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RESET  = 10'd787;
   localparam logic [SPREAD_W-1:0] SPREAD_LIMIT_RESET    = 11'd256;
   localparam logic [SAMPLE_W-1:0] SHORT_THRESHOLD_RESET = 10'd90;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [ADDR_W-1:0]   addr_type;
   typedef logic [SUM_W-1:0]    sum_type;

   typedef enum logic [1:0] {
      CSR_LOW_THRESHOLD,
      CSR_HIGH_THRESHOLD,
      CSR_SPREAD_LIMIT,
      CSR_SHORT_THRESHOLD
   } csr_index_type;

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_READ,
      SCAN_DRAIN,
      SCAN_HOLD
   } scan_state_type;

   typedef struct packed {
      logic idle;
      logic hold;
   } scan_status_type;

   typedef struct packed {
      sum_type    sum;
      sample_type lo;
      sample_type hi;
   } scan_stats_type;

endpackage

// ===== sv/awsa_window_ram.sv =====
module awsa_window_ram (
   input  logic              clock,
   input  logic              we,
   input  awsa_pkg::addr_type   waddr,
   input  awsa_pkg::sample_type wdata,
   input  awsa_pkg::addr_type   raddr,
   output awsa_pkg::sample_type rdata
);
   import awsa_pkg::*;

   sample_type mem [WINDOW_DEPTH];
   sample_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/awsa_scan.sv =====
module awsa_scan (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  awsa_pkg::sample_type      start_sample,
   input  awsa_pkg::addr_type        start_addr,
   input  logic                      take,
   output awsa_pkg::scan_status_type status,
   output awsa_pkg::scan_stats_type  stats
);
   import awsa_pkg::*;

   scan_state_type state_ff, state_in;
   addr_type       addr_ff, addr_in;
   logic           pend_ff, pend_in;
   sum_type        sum_ff, sum_in;
   sample_type     lo_ff, lo_in;
   sample_type     hi_ff, hi_in;
   sample_type     rdata;
   logic           ram_we;
   logic           last;

   awsa_window_ram u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (start_addr),
      .wdata (start_sample),
      .raddr (addr_ff),
      .rdata (rdata)
   );

   assign last = (addr_ff == ADDR_W'(WINDOW_DEPTH - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SCAN_IDLE:  if (start) state_in = SCAN_READ;
         SCAN_READ:  if (last) state_in = SCAN_DRAIN;
         SCAN_DRAIN: state_in = SCAN_HOLD;
         SCAN_HOLD:  if (take) state_in = SCAN_IDLE;
         default:    state_in = SCAN_IDLE;
      endcase
   end

   always_comb begin
      ram_we = 1'b0;
      pend_in = 1'b0;
      status.idle = 1'b0;
      status.hold = 1'b0;
      unique case (state_ff)
         SCAN_IDLE: begin
            ram_we = start;
            status.idle = 1'b1;
         end
         SCAN_READ:  pend_in = 1'b1;
         SCAN_DRAIN: ;
         SCAN_HOLD:  status.hold = 1'b1;
         default:    ;
      endcase
   end

   // sample is written at the accept edge, every read follows it
   always_comb begin
      addr_in = addr_ff;
      sum_in  = sum_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      if (ram_we) begin
         addr_in = '0;
         sum_in  = '0;
         lo_in   = '1;
         hi_in   = '0;
      end else begin
         if (state_ff == SCAN_READ) begin
            addr_in = ADDR_W'(addr_ff + 1'b1);
         end
         if (pend_ff) begin
            sum_in = sum_ff + SUM_W'(rdata);
            if (rdata < lo_ff) lo_in = rdata;
            if (rdata > hi_ff) hi_in = rdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      sum_ff  <= sum_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
   end

   assign stats.sum = sum_ff;
   assign stats.lo  = lo_ff;
   assign stats.hi  = hi_ff;

endmodule

// ===== sv/adc_window_settle_autorange.sv =====
// ADC window settle and autorange.
// Input channel req_ (valid/ready) takes one 10-bit ADC sample per item.
// The sample is written into a 128-entry ring window held in a block RAM,
// then the whole window is read back one entry per cycle for sum, minimum
// and maximum. One result item leaves on rsp_ (valid/ready) per sample:
// average_valid, average, range_select, range_changed, contacts_shorted.
// From accept to rsp_valid: the sample is written at the accept edge, every
// window entry is read in turn, the last read lands in the drain state and
// the hold state evaluates the scan and loads the output register. A new
// sample is taken only once the last scan is done, as the single RAM read
// port walks every window entry; req_ready is high only while the scan is
// idle. The result sits in an output register; the next sample is accepted
// while it waits, but a finished scan holds until the output register is
// free, so a stalled receiver stalls the block after one further item.
// The user must write thresholds and spread limit through csr_ only while
// idle; the block does not enforce it. Reset (synchronous, active high)
// restores the register defaults and clears the ring position, sample
// count and range index; window contents are not cleared, as the count
// gate covers every entry before use.
module adc_window_settle_autorange (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [9:0]              req_sample,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_average_valid,
   output logic [9:0]              rsp_average,
   output logic [2:0]              rsp_range_select,
   output logic                    rsp_range_changed,
   output logic                    rsp_contacts_shorted,
   input  logic                    csr_we,
   input  awsa_pkg::csr_index_type csr_index,
   input  logic [10:0]             csr_wdata
);
   import awsa_pkg::*;

   sample_type            low_thr_ff, high_thr_ff, short_thr_ff;
   logic [SPREAD_W-1:0]   spread_lim_ff;
   addr_type              wr_pos_ff, wr_pos_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [RANGE_W-1:0]    range_ff, range_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  avg_valid_ff;
   sample_type            average_ff;
   logic [RANGE_W-1:0]    range_sel_ff;
   logic                  changed_ff, shorted_ff;

   scan_status_type       scan_status;
   scan_stats_type        scan_stats;
   logic                  accept;
   logic                  take;
   logic                  settled;
   sample_type            spread;
   sample_type            average;
   logic                  step_down, step_up, shorted;

   assign req_ready = scan_status.idle;
   assign accept    = req_valid && req_ready;
   assign take      = scan_status.hold && (!rsp_valid_ff || rsp_ready);

   awsa_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .start        (accept),
      .start_sample (req_sample),
      .start_addr   (wr_pos_ff),
      .take         (take),
      .status       (scan_status),
      .stats        (scan_stats)
   );

   // evaluation of the finished scan
   assign spread  = scan_stats.hi - scan_stats.lo;
   assign average = SAMPLE_W'(scan_stats.sum / WINDOW_DEPTH);
   assign settled = (count_ff >= COUNT_GATE) && (SPREAD_W'(spread) < spread_lim_ff);
   assign step_down = settled && (average < low_thr_ff) && (range_ff != '0);
   assign step_up   = settled && !step_down && (average > high_thr_ff)
                      && (range_ff != RANGE_TOP);
   assign shorted   = settled && (average < short_thr_ff) && (range_ff == '0);

   always_comb begin
      wr_pos_in = wr_pos_ff;
      count_in  = count_ff;
      range_in  = range_ff;
      if (accept) begin
         wr_pos_in = (wr_pos_ff == ADDR_W'(WINDOW_DEPTH - 1)) ? '0
                                                            : ADDR_W'(wr_pos_ff + 1'b1);
         if (count_ff < COUNT_CEILING) begin
            count_in = COUNT_W'(count_ff + 1'b1);
         end
      end
      if (take) begin
         if (step_down) range_in = RANGE_W'(range_ff - 1'b1);
         if (step_up)   range_in = RANGE_W'(range_ff + 1'b1);
         if (step_down || step_up) count_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (take) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_thr_ff    <= LOW_THRESHOLD_RESET;
         high_thr_ff   <= HIGH_THRESHOLD_RESET;
         spread_lim_ff <= SPREAD_LIMIT_RESET;
         short_thr_ff  <= SHORT_THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOW_THRESHOLD:   low_thr_ff    <= csr_wdata[SAMPLE_W-1:0];
            CSR_HIGH_THRESHOLD:  high_thr_ff   <= csr_wdata[SAMPLE_W-1:0];
            CSR_SPREAD_LIMIT:    spread_lim_ff <= csr_wdata[SPREAD_W-1:0];
            CSR_SHORT_THRESHOLD: short_thr_ff  <= csr_wdata[SAMPLE_W-1:0];
            default:             ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff    <= '0;
         count_ff     <= '0;
         range_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_pos_ff    <= wr_pos_in;
         count_ff     <= count_in;
         range_ff     <= range_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         avg_valid_ff <= settled;
         average_ff   <= settled ? average : '0;
         range_sel_ff <= range_in;
         changed_ff   <= step_down || step_up;
         shorted_ff   <= shorted;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_average_valid    = avg_valid_ff;
   assign rsp_average          = average_ff;
   assign rsp_range_select     = range_sel_ff;
   assign rsp_range_changed    = changed_ff;
   assign rsp_contacts_shorted = shorted_ff;

endmodule

// ===== sv/awsa_checker.sv =====
module awsa_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_average_valid,
   input  logic [9:0] rsp_average,
   input  logic [2:0] rsp_range_select,
   input  logic       rsp_range_changed,
   input  logic       rsp_contacts_shorted
);
   import awsa_pkg::*;

   // a waiting result holds its average, range and average-valid fields
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average)
         && $stable(rsp_range_select) && $stable(rsp_average_valid))
      else $error("result changed while stalled");

   // unsettled item reports nothing but the range
   a_unsettled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_average_valid |-> rsp_average == '0
         && !rsp_range_changed && !rsp_contacts_shorted)
      else $error("unsettled item carries result fields");

   a_range_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_range_select <= RANGE_TOP)
      else $error("range index out of bounds");

   // one item at a time: the scan keeps the input closed after accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input reopened during scan");

endmodule

bind adc_window_settle_autorange awsa_checker u_checker (.*);
